### rtl/modular_square_root_top_macros.svh
// Assertion macros shared by the modular square root RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef MODULAR_SQUARE_ROOT_TOP_MACROS_SVH
`define MODULAR_SQUARE_ROOT_TOP_MACROS_SVH

// same-cycle implication under a synchronous active-high reset
`define MSR_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MSR_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/msr_pkg.sv
// Package for the modular square root block: datapath command codes,
// status struct and fixed constants. No dependencies.
`default_nettype none

package msr_pkg;

   localparam int IDX_W     = 7;     // holds counts up to 64 (S, M, i, j)
   localparam int Z_W       = 12;    // non-residue candidate counter
   localparam int NQR_LIMIT = 4096;  // candidates 2 .. NQR_LIMIT-1

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_RED_A,
      OP_POW_EUL_A,
      OP_POW_EUL_Z,
      OP_POW_SQ3,
      OP_INIT_G,
      OP_FACT,
      OP_Z_INC,
      OP_POW_C,
      OP_POW_T,
      OP_POW_R,
      OP_MUL_TT,
      OP_MUL_TMP,
      OP_B_INIT,
      OP_MUL_BB,
      OP_MUL_C,
      OP_MUL_T,
      OP_MUL_R,
      OP_OUT_ZERO,
      OP_OUT_P2,
      OP_OUT_NQR,
      OP_OUT_ROOT,
      OP_OUT_FAIL
   } op_type;

   typedef struct packed {
      logic done;       // arithmetic unit result written this cycle
      logic p_eq2;
      logic p_gt2;
      logic p_mod4_3;
      logic a_zero;
      logic pw_one;
      logic pw_pm1;
      logic q_even_nz;
      logic z_last;
      logic t_one;
      logic tmp_one;
      logic i_lt_m;
      logic j_lt_m;
   } status_type;

endpackage

`default_nettype wire

### rtl/msr_mulm.sv
// Bit-serial modular multiplier: one bit of b per cycle, double-and-add mod p.
// Operand a must be below p. No package dependencies.
`default_nettype none

module msr_mulm #(
   parameter int WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] a,
   input  wire logic [WIDTH-1:0] b,
   input  wire logic [WIDTH-1:0] p,
   output logic                  done,
   output logic [WIDTH-1:0]      result
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] r_ff, b_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff, done_ff;
   logic [WIDTH:0]   sum1, sum2, pw;
   logic [WIDTH-1:0] r1, r2;

   assign pw = {1'b0, p};

   always_comb begin
      sum1 = {1'b0, r_ff} + {1'b0, r_ff};
      r1   = (sum1 >= pw) ? WIDTH'(sum1 - pw) : sum1[WIDTH-1:0];
      sum2 = {1'b0, r1} + {1'b0, a};
      if (b_ff[WIDTH-1]) begin
         r2 = (sum2 >= pw) ? WIDTH'(sum2 - pw) : sum2[WIDTH-1:0];
      end else begin
         r2 = r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            r_ff    <= '0;
            b_ff    <= b;
            cnt_ff  <= CW'(WIDTH);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            r_ff   <= r2;
            b_ff   <= b_ff << 1;
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = r_ff;

endmodule

`default_nettype wire

### rtl/msr_pow.sv
// Modular exponentiation and single-product unit over one shared msr_mulm.
// Left-to-right square and multiply; bases must be below p.
`default_nettype none

module msr_pow #(
   parameter int WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             mode_pow,
   input  wire logic [WIDTH-1:0] x,
   input  wire logic [WIDTH-1:0] y,
   input  wire logic [WIDTH-1:0] p,
   output logic                  done,
   output logic [WIDTH-1:0]      result
);

   localparam int CW = $clog2(WIDTH + 1);

   typedef enum logic [2:0] {P_IDLE, P_MUL, P_SQ, P_SQW, P_ML, P_MLW} pstate_type;

   pstate_type       state_ff;
   logic [WIDTH-1:0] x_ff, e_ff, acc_ff, ma_ff, mb_ff;
   logic [CW-1:0]    cnt_ff;
   logic             done_ff, m_start_ff, m_done;
   logic [WIDTH-1:0] m_res;
   logic             acc_one;

   assign acc_one = (acc_ff == WIDTH'(1));

   msr_mulm #(.WIDTH(WIDTH)) u_mulm (
      .clock  (clock),
      .reset  (reset),
      .start  (m_start_ff),
      .a      (ma_ff),
      .b      (mb_ff),
      .p      (p),
      .done   (m_done),
      .result (m_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= P_IDLE;
         done_ff    <= 1'b0;
         m_start_ff <= 1'b0;
      end else begin
         done_ff    <= 1'b0;
         m_start_ff <= 1'b0;
         case (state_ff)
            P_IDLE: begin
               if (start) begin
                  x_ff   <= x;
                  e_ff   <= y;
                  acc_ff <= WIDTH'(1);
                  cnt_ff <= CW'(WIDTH);
                  if (mode_pow) begin
                     state_ff <= P_SQ;
                  end else begin
                     ma_ff      <= x;
                     mb_ff      <= y;
                     m_start_ff <= 1'b1;
                     state_ff   <= P_MUL;
                  end
               end
            end
            P_MUL: begin
               if (m_done) begin
                  acc_ff   <= m_res;
                  done_ff  <= 1'b1;
                  state_ff <= P_IDLE;
               end
            end
            P_SQ: begin
               if (cnt_ff == '0) begin
                  done_ff  <= 1'b1;
                  state_ff <= P_IDLE;
               end else if (acc_one) begin
                  // squaring one gives one: skip it
                  state_ff <= P_ML;
               end else begin
                  ma_ff      <= acc_ff;
                  mb_ff      <= acc_ff;
                  m_start_ff <= 1'b1;
                  state_ff   <= P_SQW;
               end
            end
            P_SQW: begin
               if (m_done) begin
                  acc_ff   <= m_res;
                  state_ff <= P_ML;
               end
            end
            P_ML: begin
               if (!e_ff[WIDTH-1]) begin
                  e_ff     <= e_ff << 1;
                  cnt_ff   <= cnt_ff - CW'(1);
                  state_ff <= P_SQ;
               end else if (acc_one) begin
                  acc_ff   <= x_ff;
                  e_ff     <= e_ff << 1;
                  cnt_ff   <= cnt_ff - CW'(1);
                  state_ff <= P_SQ;
               end else begin
                  ma_ff      <= acc_ff;
                  mb_ff      <= x_ff;
                  m_start_ff <= 1'b1;
                  state_ff   <= P_MLW;
               end
            end
            P_MLW: begin
               if (m_done) begin
                  acc_ff   <= m_res;
                  e_ff     <= e_ff << 1;
                  cnt_ff   <= cnt_ff - CW'(1);
                  state_ff <= P_SQ;
               end
            end
            default: state_ff <= P_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

`default_nettype wire

### rtl/msr_dp.sv
// Datapath of the modular square root block: operand registers, output
// payload and the exponentiation unit. Uses msr_pkg and msr_pow.
`default_nettype none

module msr_dp #(
   parameter int WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire msr_pkg::op_type  op,
   input  wire logic [WIDTH-1:0] req_value,
   input  wire logic [WIDTH-1:0] req_modulus,
   output msr_pkg::status_type   status,
   output logic [WIDTH-1:0]      rsp_root,
   output logic [1:0]            rsp_symbol
);

   localparam int IW = msr_pkg::IDX_W;
   localparam int ZW = msr_pkg::Z_W;

   typedef enum logic [2:0] {D_A, D_PW, D_R, D_C, D_T, D_TMP, D_B} dest_type;

   logic [WIDTH-1:0] v_ff, p_ff, a_ff, pw_ff, q_ff, zr_ff;
   logic [WIDTH-1:0] c_ff, t_ff, r_ff, b_ff, tmp_ff, root_ff;
   logic [IW-1:0]    s_ff, m_ff, i_ff, j_ff;
   logic [ZW-1:0]    z_ff;
   logic [1:0]       sym_ff;
   dest_type         dest_ff, dest_sel;

   logic             u_start, u_pow, u_done;
   logic [WIDTH-1:0] u_x, u_y, u_res;
   logic [WIDTH-1:0] e_eul, e_sq3, e_r;
   logic [WIDTH:0]   zr_inc;

   assign e_eul  = (p_ff - WIDTH'(1)) >> 1;
   assign e_sq3  = (p_ff >> 2) + WIDTH'(1);
   assign e_r    = (q_ff >> 1) + WIDTH'(1);
   assign zr_inc = {1'b0, zr_ff} + (WIDTH + 1)'(1);

   always_comb begin
      u_start  = 1'b1;
      u_pow    = 1'b1;
      u_x      = a_ff;
      u_y      = e_eul;
      dest_sel = D_PW;
      case (op)
         msr_pkg::OP_RED_A: begin
            // x * 1 walked over the bits of v leaves v mod p
            u_pow = 1'b0; u_x = WIDTH'(1); u_y = v_ff; dest_sel = D_A;
         end
         msr_pkg::OP_POW_EUL_A: begin
            u_x = a_ff; u_y = e_eul; dest_sel = D_PW;
         end
         msr_pkg::OP_POW_EUL_Z: begin
            u_x = zr_ff; u_y = e_eul; dest_sel = D_PW;
         end
         msr_pkg::OP_POW_SQ3: begin
            u_x = a_ff; u_y = e_sq3; dest_sel = D_R;
         end
         msr_pkg::OP_POW_C: begin
            u_x = zr_ff; u_y = q_ff; dest_sel = D_C;
         end
         msr_pkg::OP_POW_T: begin
            u_x = a_ff; u_y = q_ff; dest_sel = D_T;
         end
         msr_pkg::OP_POW_R: begin
            u_x = a_ff; u_y = e_r; dest_sel = D_R;
         end
         msr_pkg::OP_MUL_TT: begin
            u_pow = 1'b0; u_x = t_ff; u_y = t_ff; dest_sel = D_TMP;
         end
         msr_pkg::OP_MUL_TMP: begin
            u_pow = 1'b0; u_x = tmp_ff; u_y = tmp_ff; dest_sel = D_TMP;
         end
         msr_pkg::OP_MUL_BB: begin
            u_pow = 1'b0; u_x = b_ff; u_y = b_ff; dest_sel = D_B;
         end
         msr_pkg::OP_MUL_C: begin
            u_pow = 1'b0; u_x = b_ff; u_y = b_ff; dest_sel = D_C;
         end
         msr_pkg::OP_MUL_T: begin
            u_pow = 1'b0; u_x = t_ff; u_y = c_ff; dest_sel = D_T;
         end
         msr_pkg::OP_MUL_R: begin
            u_pow = 1'b0; u_x = r_ff; u_y = b_ff; dest_sel = D_R;
         end
         default: u_start = 1'b0;
      endcase
   end

   msr_pow #(.WIDTH(WIDTH)) u_pow_unit (
      .clock    (clock),
      .reset    (reset),
      .start    (u_start),
      .mode_pow (u_pow),
      .x        (u_x),
      .y        (u_y),
      .p        (p_ff),
      .done     (u_done),
      .result   (u_res)
   );

   always_ff @(posedge clock) begin
      if (u_start) begin
         dest_ff <= dest_sel;
      end
      if (u_done) begin
         case (dest_ff)
            D_A:     a_ff   <= u_res;
            D_PW:    pw_ff  <= u_res;
            D_R:     r_ff   <= u_res;
            D_C:     c_ff   <= u_res;
            D_T:     t_ff   <= u_res;
            D_TMP:   tmp_ff <= u_res;
            D_B:     b_ff   <= u_res;
            default: pw_ff  <= u_res;
         endcase
      end
      case (op)
         msr_pkg::OP_LOAD: begin
            v_ff <= req_value;
            p_ff <= req_modulus;
         end
         msr_pkg::OP_INIT_G: begin
            q_ff  <= p_ff - WIDTH'(1);
            s_ff  <= '0;
            z_ff  <= ZW'(2);
            zr_ff <= WIDTH'(2);
         end
         msr_pkg::OP_FACT: begin
            q_ff <= q_ff >> 1;
            s_ff <= s_ff + IW'(1);
         end
         msr_pkg::OP_Z_INC: begin
            z_ff  <= z_ff + ZW'(1);
            zr_ff <= (zr_inc == {1'b0, p_ff}) ? '0 : zr_inc[WIDTH-1:0];
         end
         msr_pkg::OP_POW_C:   m_ff <= s_ff;
         msr_pkg::OP_MUL_TT:  i_ff <= IW'(1);
         msr_pkg::OP_MUL_TMP: i_ff <= i_ff + IW'(1);
         msr_pkg::OP_B_INIT: begin
            b_ff <= c_ff;
            j_ff <= i_ff + IW'(1);
         end
         msr_pkg::OP_MUL_BB:  j_ff <= j_ff + IW'(1);
         msr_pkg::OP_MUL_C:   m_ff <= i_ff;
         msr_pkg::OP_OUT_ZERO: begin
            root_ff <= '0;
            sym_ff  <= 2'd0;
         end
         msr_pkg::OP_OUT_P2: begin
            root_ff <= WIDTH'(v_ff[0]);
            sym_ff  <= {1'b0, v_ff[0]};
         end
         msr_pkg::OP_OUT_NQR: begin
            root_ff <= '0;
            sym_ff  <= 2'd2;
         end
         msr_pkg::OP_OUT_ROOT: begin
            root_ff <= r_ff;
            sym_ff  <= 2'd1;
         end
         msr_pkg::OP_OUT_FAIL: begin
            root_ff <= '0;
            sym_ff  <= 2'd1;
         end
         default: ;
      endcase
   end

   always_comb begin
      status.done      = u_done;
      status.p_eq2     = (p_ff == WIDTH'(2));
      status.p_gt2     = (p_ff > WIDTH'(2));
      status.p_mod4_3  = (p_ff[1:0] == 2'b11);
      status.a_zero    = (a_ff == '0);
      status.pw_one    = (pw_ff == WIDTH'(1));
      status.pw_pm1    = (pw_ff == p_ff - WIDTH'(1));
      status.q_even_nz = (q_ff != '0) && !q_ff[0];
      status.z_last    = (z_ff == ZW'(msr_pkg::NQR_LIMIT - 1));
      status.t_one     = (t_ff == WIDTH'(1));
      status.tmp_one   = (tmp_ff == WIDTH'(1));
      status.i_lt_m    = (i_ff < m_ff);
      status.j_lt_m    = (j_ff < m_ff);
   end

   assign rsp_root   = root_ff;
   assign rsp_symbol = sym_ff;

endmodule

`default_nettype wire

### rtl/msr_ctrl.sv
// Controller of the modular square root block: sequences the datapath
// commands and owns both handshakes. Uses msr_pkg and the assertion macros.
`default_nettype none
`include "modular_square_root_top_macros.svh"

module msr_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire msr_pkg::status_type status,
   output msr_pkg::op_type          op
);

   typedef enum logic [4:0] {
      S_IDLE, S_CHK, S_RED_W, S_RED_D, S_EUL_W, S_EUL_D, S_SQ3_W, S_FACT,
      S_ZEUL_W, S_ZEUL_D, S_PC_W, S_PT, S_PT_W, S_PR, S_PR_W, S_LOOP,
      S_TT_W, S_TMP, S_TMP_W, S_BCHK, S_BB_W, S_MC_W, S_MT, S_MT_W,
      S_MR, S_MR_W, S_FIN
   } state_type;

   typedef enum logic [2:0] {K_ZERO, K_P2, K_NQR, K_ROOT, K_FAIL} kind_type;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   logic      rsp_valid_ff, slot_free, out_issue, is_wait;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      op       = msr_pkg::OP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op = msr_pkg::OP_LOAD;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (status.p_eq2) begin
               kind_in = K_P2; state_in = S_FIN;
            end else if (!status.p_gt2) begin
               kind_in = K_ZERO; state_in = S_FIN;
            end else begin
               op = msr_pkg::OP_RED_A; state_in = S_RED_W;
            end
         end
         S_RED_W: if (status.done) state_in = S_RED_D;
         S_RED_D: begin
            if (status.a_zero) begin
               kind_in = K_ZERO; state_in = S_FIN;
            end else begin
               op = msr_pkg::OP_POW_EUL_A; state_in = S_EUL_W;
            end
         end
         S_EUL_W: if (status.done) state_in = S_EUL_D;
         S_EUL_D: begin
            if (!status.pw_one) begin
               kind_in = K_NQR; state_in = S_FIN;
            end else if (status.p_mod4_3) begin
               op = msr_pkg::OP_POW_SQ3; state_in = S_SQ3_W;
            end else begin
               op = msr_pkg::OP_INIT_G; state_in = S_FACT;
            end
         end
         S_SQ3_W: begin
            if (status.done) begin
               kind_in = K_ROOT; state_in = S_FIN;
            end
         end
         S_FACT: begin
            // strip factors of two from p-1, then test the current candidate
            if (status.q_even_nz) begin
               op = msr_pkg::OP_FACT;
            end else begin
               op = msr_pkg::OP_POW_EUL_Z; state_in = S_ZEUL_W;
            end
         end
         S_ZEUL_W: if (status.done) state_in = S_ZEUL_D;
         S_ZEUL_D: begin
            if (status.pw_pm1) begin
               op = msr_pkg::OP_POW_C; state_in = S_PC_W;
            end else if (status.z_last) begin
               kind_in = K_FAIL; state_in = S_FIN;
            end else begin
               op = msr_pkg::OP_Z_INC; state_in = S_FACT;
            end
         end
         S_PC_W: if (status.done) state_in = S_PT;
         S_PT: begin
            op = msr_pkg::OP_POW_T; state_in = S_PT_W;
         end
         S_PT_W: if (status.done) state_in = S_PR;
         S_PR: begin
            op = msr_pkg::OP_POW_R; state_in = S_PR_W;
         end
         S_PR_W: if (status.done) state_in = S_LOOP;
         S_LOOP: begin
            if (status.t_one) begin
               kind_in = K_ROOT; state_in = S_FIN;
            end else begin
               op = msr_pkg::OP_MUL_TT; state_in = S_TT_W;
            end
         end
         S_TT_W: if (status.done) state_in = S_TMP;
         S_TMP: begin
            if (!status.tmp_one && status.i_lt_m) begin
               op = msr_pkg::OP_MUL_TMP; state_in = S_TMP_W;
            end else if (!status.i_lt_m) begin
               kind_in = K_FAIL; state_in = S_FIN;
            end else begin
               op = msr_pkg::OP_B_INIT; state_in = S_BCHK;
            end
         end
         S_TMP_W: if (status.done) state_in = S_TMP;
         S_BCHK: begin
            if (status.j_lt_m) begin
               op = msr_pkg::OP_MUL_BB; state_in = S_BB_W;
            end else begin
               op = msr_pkg::OP_MUL_C; state_in = S_MC_W;
            end
         end
         S_BB_W: if (status.done) state_in = S_BCHK;
         S_MC_W: if (status.done) state_in = S_MT;
         S_MT: begin
            op = msr_pkg::OP_MUL_T; state_in = S_MT_W;
         end
         S_MT_W: if (status.done) state_in = S_MR;
         S_MR: begin
            op = msr_pkg::OP_MUL_R; state_in = S_MR_W;
         end
         S_MR_W: if (status.done) state_in = S_LOOP;
         S_FIN: begin
            // hold the result until the output register can take it
            if (slot_free) begin
               state_in = S_IDLE;
               case (kind_ff)
                  K_ZERO:  op = msr_pkg::OP_OUT_ZERO;
                  K_P2:    op = msr_pkg::OP_OUT_P2;
                  K_NQR:   op = msr_pkg::OP_OUT_NQR;
                  K_ROOT:  op = msr_pkg::OP_OUT_ROOT;
                  K_FAIL:  op = msr_pkg::OP_OUT_FAIL;
                  default: op = msr_pkg::OP_OUT_ZERO;
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign out_issue = (state_ff == S_FIN) && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= K_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         if (out_issue) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign is_wait = (state_ff == S_RED_W) || (state_ff == S_EUL_W) ||
                    (state_ff == S_SQ3_W) || (state_ff == S_ZEUL_W) ||
                    (state_ff == S_PC_W)  || (state_ff == S_PT_W) ||
                    (state_ff == S_PR_W)  || (state_ff == S_TT_W) ||
                    (state_ff == S_TMP_W) || (state_ff == S_BB_W) ||
                    (state_ff == S_MC_W)  || (state_ff == S_MT_W) ||
                    (state_ff == S_MR_W);

   `MSR_ASSERT_IMP(a_done_in_wait, clock, reset, status.done, is_wait, "unit done outside wait")
   `MSR_ASSERT_NXT(a_done_pulse, clock, reset, status.done, !status.done, "unit done not a pulse")
   `MSR_ASSERT_IMP(a_out_free, clock, reset, out_issue, (!rsp_valid_ff || !rsp_stall), "result overwritten")

endmodule

`default_nettype wire

### rtl/modular_square_root_top.sv
// Modular square root (Legendre symbol plus Tonelli-Shanks root) for a prime
// modulus of WIDTH bits. One item is in work at a time; a finished result waits
// in the output register while the next item is taken. Every product goes
// through one bit-serial modular multiplier, and an exponentiation costs up to
// 2*WIDTH products. A modulus of two or below finishes with no product, a zero
// value after one reduction, a non-residue after one reduction and one
// exponentiation, a residue for a modulus of 3 mod 4 after one reduction and two
// exponentiations; other moduli add one exponentiation per candidate tried,
// three more, and the squaring loop. Built from msr_ctrl (sequencer) and msr_dp
// (registers and arithmetic), using msr_pkg.
`default_nettype none

module modular_square_root_top #(
   parameter int WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [WIDTH-1:0] req_value,
   input  wire logic [WIDTH-1:0] req_modulus,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [WIDTH-1:0]      rsp_root,
   output logic [1:0]            rsp_symbol
);

   msr_pkg::op_type     op;
   msr_pkg::status_type status;

   msr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .op        (op)
   );

   msr_dp #(.WIDTH(WIDTH)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .req_value   (req_value),
      .req_modulus (req_modulus),
      .status      (status),
      .rsp_root    (rsp_root),
      .rsp_symbol  (rsp_symbol)
   );

endmodule

`default_nettype wire
